/* design/rrqs_pkg.sv */
`default_nettype none

package rrqs_pkg;

	localparam int unsigned QUANTUM_RESET = 4;

	typedef enum logic {
		OP_ADD   = 1'b0,
		OP_SERVE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_ADDED  = 2'd0,
		ST_FULL   = 2'd1,
		ST_SERVED = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} ctrl_state_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  job_id;
		logic [15:0] burst_time;
	} in_word_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  served_id;
		logic [15:0] remaining_before;
		logic [15:0] remaining_after;
		logic        finished;
		logic [4:0]  jobs_left;
	} out_word_t;

	typedef struct packed {
		logic [7:0]  job_id;
		logic [15:0] remaining;
	} slot_t;

	typedef struct packed {
		logic latch;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

/* design/rrqs_ifs.sv */
`default_nettype none

interface rrqs_in_if;
	import rrqs_pkg::*;
	logic     valid;
	logic     ready;
	in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rrqs_out_if;
	import rrqs_pkg::*;
	logic      valid;
	logic      ready;
	out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/rrqs_ctrl.sv */
`default_nettype none

module rrqs_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          item_valid,
	output logic               item_ready,
	input  rrqs_pkg::stat_t    stat,
	output rrqs_pkg::cmd_t     cmd
);
	import rrqs_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		cmd        = '0;
		case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

/* design/rrqs_datapath.sv */
`default_nettype none

module rrqs_datapath #(
	parameter int unsigned MAX_JOBS = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           quantum_we,
	input  wire logic [15:0]    quantum_wdata,
	input  rrqs_pkg::in_word_t  item_data,
	input  rrqs_pkg::cmd_t      cmd,
	output rrqs_pkg::stat_t     stat,
	output logic                out_valid,
	input  wire logic           out_ready,
	output rrqs_pkg::out_word_t out_data
);
	import rrqs_pkg::*;

	localparam int unsigned IW = $clog2(MAX_JOBS);
	localparam int unsigned CW = $clog2(MAX_JOBS + 1);
	localparam int unsigned SW = CW + 1;

	slot_t slot_mem [MAX_JOBS];

	logic [15:0]   quantum_q;
	logic [IW-1:0] front_q;
	logic [CW-1:0] count_q;
	logic          out_valid_q;
	out_word_t     out_q;
	in_word_t      item_q;
	slot_t         rd_q;

	logic          full;
	logic          empty;
	logic [SW-1:0] sum_w;
	logic [SW-1:0] back_w;
	logic [IW-1:0] back_idx;
	logic [IW-1:0] front_inc;
	logic [15:0]   rem_sub;
	logic          mem_we;
	slot_t         mem_wd;
	logic [IW-1:0] front_d;
	logic [CW-1:0] count_d;
	out_word_t     res_d;
	logic [CW+4:0] cnt_ext;

	assign full      = (count_q == CW'(MAX_JOBS));
	assign empty     = (count_q == '0);
	assign sum_w     = SW'(front_q) + SW'(count_q);
	assign back_w    = (sum_w >= SW'(MAX_JOBS)) ? (sum_w - SW'(MAX_JOBS)) : sum_w;
	assign back_idx  = back_w[IW-1:0];
	assign front_inc = (front_q == IW'(MAX_JOBS - 1)) ? '0 : (front_q + IW'(1));
	assign rem_sub   = rd_q.remaining - quantum_q;

	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign out_data      = out_q;

	always_comb begin
		mem_we  = 1'b0;
		mem_wd  = '{job_id: item_q.job_id, remaining: item_q.burst_time};
		front_d = front_q;
		count_d = count_q;
		res_d   = '0;
		case (item_q.op)
			OP_ADD: begin
				if (full) begin
					res_d.status = ST_FULL;
				end else begin
					res_d.status = ST_ADDED;
					mem_we       = 1'b1;
					count_d      = count_q + CW'(1);
				end
			end
			OP_SERVE: begin
				if (empty) begin
					res_d.status = ST_EMPTY;
				end else begin
					res_d.status           = ST_SERVED;
					res_d.served_id        = rd_q.job_id;
					res_d.remaining_before = rd_q.remaining;
					front_d                = front_inc;
					if (rd_q.remaining > quantum_q) begin
						mem_we                = 1'b1;
						mem_wd                = '{job_id: rd_q.job_id, remaining: rem_sub};
						res_d.remaining_after = rem_sub;
					end else begin
						count_d        = count_q - CW'(1);
						res_d.finished = 1'b1;
					end
				end
			end
			default: begin
				res_d.status = ST_ADDED;
			end
		endcase
		cnt_ext         = {5'b0, count_d};
		res_d.jobs_left = cnt_ext[4:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && mem_we) begin
			slot_mem[back_idx] <= mem_wd;
		end
		rd_q <= slot_mem[front_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			item_q <= item_data;
		end
		if (cmd.commit) begin
			out_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q   <= 16'(QUANTUM_RESET);
			front_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (quantum_we) begin
				quantum_q <= quantum_wdata;
			end
			if (cmd.commit) begin
				front_q     <= front_d;
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* design/round_robin_quantum_scheduler_core.sv */
// channel   dir  handshake     word
// item      in   valid/ready   op, job_id, burst_time
// result    out  valid/ready   status, served_id, remaining_before,
//                              remaining_after, finished, jobs_left
// quantum   in   quantum_we    quantum_wdata (16 bits)
//
// Each item is captured in the idle state, which also reads the front slot from
// the ring memory; the execute state updates the ring and the result register.
// The next item is taken while a result still waits in the result register.
// A held result stalls the update cycle of the following item until it is taken.
// Reset empties the ring and sets quantum to 4; no clearing pass is needed.
`default_nettype none

module round_robin_quantum_scheduler_core #(
	parameter int unsigned MAX_JOBS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        quantum_we,
	input  wire logic [15:0] quantum_wdata,
	rrqs_in_if.sink          item,
	rrqs_out_if.source       result
);
	import rrqs_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	rrqs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	rrqs_datapath #(
		.MAX_JOBS (MAX_JOBS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.quantum_we    (quantum_we),
		.quantum_wdata (quantum_wdata),
		.item_data     (item.data),
		.cmd           (cmd),
		.stat          (stat),
		.out_valid     (result.valid),
		.out_ready     (result.ready),
		.out_data      (result.data)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> !item.ready)
		else $error("item taken while previous item in flight");

	a_result_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(cmd.commit))
		else $error("result appeared without a commit");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.data.status == ST_FULL) |->
		(result.data.jobs_left == 5'(MAX_JOBS)))
		else $error("full reported with ring not full");

	a_unserved_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.data.status != ST_SERVED) |->
		(result.data.served_id == '0) && !result.data.finished &&
		(result.data.remaining_after == '0))
		else $error("served fields set on a result that served nothing");

endmodule

`default_nettype wire

/* sim/rrqs_slice_scoreboard.sv */
`default_nettype none

module rrqs_slice_scoreboard
	import rrqs_pkg::*;
#(
	parameter int unsigned MAX_JOBS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        quantum_we,
	input  wire logic [15:0] quantum_wdata,
	rrqs_in_if               item_mon,
	rrqs_out_if              result_mon,
	output int unsigned      fails,
	output int unsigned      pending,
	output int unsigned      n_results,
	output int unsigned      n_finished,
	output int unsigned      n_full,
	output int unsigned      n_empty
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [7:0]  ring_id [MAX_JOBS];
	logic [15:0] ring_rem [MAX_JOBS];
	int unsigned head;
	int unsigned depth;
	logic [15:0] slice;
	out_word_t   due_q [$];
	int unsigned errors;

	assign fails = errors;

	task automatic flag(input string what, input logic [15:0] want, input logic [15:0] seen);
		$display("mismatch at result %0d: %s expected %0h got %0h", n_results, what, want, seen);
		errors++;
	endtask

	task automatic schedule(input in_word_t w, output out_word_t r);
		int unsigned tail;
		r = '0;
		if (w.op == OP_ADD) begin
			if (depth >= MAX_JOBS) begin
				r.status = ST_FULL;
			end else begin
				tail = (head + depth) % MAX_JOBS;
				ring_id[tail] = w.job_id;
				ring_rem[tail] = w.burst_time;
				depth++;
				r.status = ST_ADDED;
			end
		end else if (depth == 0) begin
			r.status = ST_EMPTY;
		end else begin
			r.status = ST_SERVED;
			r.served_id = ring_id[head];
			r.remaining_before = ring_rem[head];
			if (ring_rem[head] > slice) begin
				r.remaining_after = ring_rem[head] - slice;
				tail = (head + depth) % MAX_JOBS;
				ring_id[tail] = r.served_id;
				ring_rem[tail] = r.remaining_after;
			end else begin
				r.finished = 1'b1;
				depth--;
			end
			head = (head + 1) % MAX_JOBS;
		end
		r.jobs_left = 5'(depth);
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		out_word_t seen;
		if (!arst_n) begin
			slice = 16'(QUANTUM_RESET);
			head = 0;
			depth = 0;
			due_q.delete();
			errors = 0;
			n_results = 0;
			n_finished = 0;
			n_full = 0;
			n_empty = 0;
			pending <= 0;
		end else begin
			if (quantum_we)
				slice = quantum_wdata;
			if (result_mon.valid && result_mon.ready) begin
				seen = result_mon.data;
				if (due_q.size() == 0) begin
					flag("unexpected result, status", 16'd0, 16'(seen.status));
				end else begin
					want = due_q.pop_front();
					if (seen.status !== want.status)
						flag("status", 16'(want.status), 16'(seen.status));
					if (seen.served_id !== want.served_id)
						flag("served_id", 16'(want.served_id), 16'(seen.served_id));
					if (seen.remaining_before !== want.remaining_before)
						flag("remaining_before", want.remaining_before, seen.remaining_before);
					if (seen.remaining_after !== want.remaining_after)
						flag("remaining_after", want.remaining_after, seen.remaining_after);
					if (seen.finished !== want.finished)
						flag("finished", 16'(want.finished), 16'(seen.finished));
					if (seen.jobs_left !== want.jobs_left)
						flag("jobs_left", 16'(want.jobs_left), 16'(seen.jobs_left));
					case (want.status)
						ST_FULL:  n_full++;
						ST_EMPTY: n_empty++;
						default:  n_finished += want.finished;
					endcase
				end
				n_results++;
			end
			if (item_mon.valid && item_mon.ready) begin
				schedule(item_mon.data, want);
				due_q.push_back(want);
			end
			pending <= due_q.size();
		end
	end

endmodule

`default_nettype wire

/* sim/tb_round_robin_quantum_scheduler_core.sv */
`default_nettype none

module tb_round_robin_quantum_scheduler_core;
	timeunit 1ns;
	timeprecision 1ps;

	import rrqs_pkg::*;

	localparam int unsigned JOBS        = 16;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned SETTLE      = 8;
	localparam int unsigned PHASES      = 8;
	localparam int unsigned PHASE_ITEMS = 100;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        quantum_we;
	logic [15:0] quantum_wdata;
	logic [15:0] cur_quantum;
	bit          calm;
	int unsigned idle_cycles;
	int unsigned sent;
	int unsigned settings;
	int unsigned fails;
	int unsigned pending;
	int unsigned n_results;
	int unsigned n_finished;
	int unsigned n_full;
	int unsigned n_empty;

	rrqs_in_if  item ();
	rrqs_out_if result ();

	round_robin_quantum_scheduler_core #(.MAX_JOBS(JOBS)) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.quantum_we    (quantum_we),
		.quantum_wdata (quantum_wdata),
		.item          (item),
		.result        (result)
	);

	rrqs_slice_scoreboard #(.MAX_JOBS(JOBS)) ring_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.quantum_we    (quantum_we),
		.quantum_wdata (quantum_wdata),
		.item_mon      (item),
		.result_mon    (result),
		.fails         (fails),
		.pending       (pending),
		.n_results     (n_results),
		.n_finished    (n_finished),
		.n_full        (n_full),
		.n_empty       (n_empty)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || (item.valid && item.ready) || (result.valid && result.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic int unsigned draw_gap();
		return calm ? 0 : $urandom_range(0, 19);
	endfunction

	function automatic logic [15:0] draw_burst(input logic [15:0] q);
		int unsigned span;
		span = q;
		span = span * 3;
		if (span > 65535)
			span = 65535;
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 65535));
			1: return 16'($urandom_range(0, span));
			2: begin
				case ($urandom_range(0, 3))
					0:       return 16'd0;
					1:       return q;
					2:       return q + 16'd1;
					default: return 16'hFFFF;
				endcase
			end
			default: return 16'($urandom_range(0, 20));
		endcase
	endfunction

	task automatic send(input op_t op, input logic [7:0] id, input logic [15:0] burst);
		int unsigned gap;
		gap = draw_gap();
		if (gap != 0) begin
			item.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item.valid <= 1'b1;
		item.data <= in_word_t'{op: op, job_id: id, burst_time: burst};
		do @(posedge clk); while (!item.ready);
		sent++;
	endtask

	task automatic drain();
		item.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_quantum(input logic [15:0] q);
		drain();
		quantum_we <= 1'b1;
		quantum_wdata <= q;
		@(posedge clk);
		quantum_we <= 1'b0;
		cur_quantum = q;
		settings++;
	endtask

	initial begin
		int unsigned gap;
		result.ready <= 1'b0;
		wait (arst_n);
		forever begin
			gap = draw_gap();
			if (gap != 0) begin
				result.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result.ready <= 1'b1;
			do @(posedge clk); while (!result.valid);
		end
	end

	initial begin
		logic [15:0] phase_q [PHASES];
		int unsigned add_pct;
		item.valid <= 1'b0;
		item.data <= '0;
		quantum_we <= 1'b0;
		quantum_wdata <= '0;
		cur_quantum = 16'(QUANTUM_RESET);
		sent = 0;
		settings = 0;
		calm = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty serve, zero burst, field extremes, rotation, fill to full, full drop
		send(OP_SERVE, 8'h00, 16'h0000);
		send(OP_ADD, 8'h00, 16'h0000);
		send(OP_ADD, 8'hFF, 16'hFFFF);
		send(OP_ADD, 8'hA5, 16'd5);
		send(OP_SERVE, 8'hFF, 16'hFFFF);
		send(OP_SERVE, 8'h00, 16'h0000);
		send(OP_SERVE, 8'h5A, 16'h1234);
		for (int i = 0; i < 14; i++)
			send(OP_ADD, 8'($urandom_range(0, 255)), draw_burst(cur_quantum));
		send(OP_ADD, 8'h3C, 16'h00FF);
		send(OP_SERVE, 8'h00, 16'h0000);

		phase_q[0] = 16'd1;
		phase_q[1] = 16'hFFFF;
		phase_q[2] = 16'd0;
		phase_q[3] = 16'(QUANTUM_RESET);
		phase_q[4] = 16'($urandom_range(1, 65535));
		phase_q[5] = 16'd2;
		phase_q[6] = 16'($urandom_range(1, 64));
		phase_q[7] = 16'd7;

		for (int p = 0; p < PHASES; p++) begin
			set_quantum(phase_q[p]);
			calm = (p % 3 == 1);
			case ($urandom_range(0, 2))
				0:       add_pct = 30;
				1:       add_pct = 50;
				default: add_pct = 70;
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(0, 99) < add_pct)
					send(OP_ADD, 8'($urandom_range(0, 255)), draw_burst(cur_quantum));
				else
					send(OP_SERVE, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
				if ($urandom_range(0, 39) == 0)
					drain();
			end
		end

		drain();
		$display("%0d items over %0d quantum settings, %0d results checked", sent,
			settings + 1, n_results);
		$display("%0d jobs completed, %0d dropped on a full ring, %0d serves on an empty ring",
			n_finished, n_full, n_empty);
		if (fails == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
